// ===== rtl/core/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       message_end;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_byte;    // write input byte, bump count
    logic put_pad;      // write 0x80 at current position
    logic put_len;      // write bit length into words 14, 15
    logic start;        // load schedule and working vars
    logic round;        // run one round
    logic fold;         // add working vars into chain, clear block
    logic emit_shift;   // shift chain for output
    logic reinit;       // reset chain, block and count
  } sha_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [5:0] pos;    // byte position in block
    logic       last_round;
  } sha_stat_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_message_hasher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | sha256_pkg::in_req_t  (byte, has_byte, end)
// out     | out | out_valid/out_stall| sha256_pkg::out_req_t (word, index, last)
//
// A byte that does not complete a block is written into the block. A block
// completion runs a load, 64 rounds and a fold on the single shared round
// unit. Finishing runs a pad step, a load, 64 rounds and a fold per
// padding block (one or two), then eight output requests, one per cycle
// unless stalled.
// rst is synchronous and restores the initial chain, an empty block and a
// zero byte count. in_stall stays high while a block compresses or words go out.
module sha256_message_hasher_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sha256_pkg::in_req_t   in_req,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sha256_pkg::out_req_t       out_req
);
  import sha256_pkg::*;

  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [2:0]  out_index;
  logic [31:0] head_word;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_index (out_index),
    .cmd       (cmd),
    .stat      (stat)
  );

  sha256_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (in_req.data_byte),
    .stat      (stat),
    .head_word (head_word)
  );

  assign out_req.digest_word = head_word;
  assign out_req.word_index  = out_index;
  assign out_req.digest_last = (out_index == 3'd7);
endmodule
`default_nettype wire

// ===== rtl/core/sha256_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha256_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha256_pkg::sha_cmd_t  cmd,
  input  wire logic [7:0]            data_byte,
  output sha256_pkg::sha_stat_t      stat,
  output logic [31:0]                head_word
);
  import sha256_pkg::*;

  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [60:0] byte_count;
  logic [31:0] win [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;

  logic [31:0] w_t, sg0, sg1, s0, s1, ch, mj, t1, t2;
  logic [31:0] w2, w15;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [63:0] bits;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign w2  = win[14];
  assign w15 = win[1];
  assign sg1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign sg0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  // Window is a shift line: win[0] is w[t] for rounds below 16.
  assign w_t = (rnd < 6'd16) ? win[0] : (sg1 + win[9] + sg0 + win[0]);
  assign s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1  = v[7] + s1 + ch + round_k(rnd) + w_t;
  assign s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign mj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2  = s0 + mj;

  assign wr_pos  = byte_count[5:0];
  assign wr_byte = cmd.put_pad ? PAD_BYTE : data_byte;
  assign bits    = {byte_count, 3'b000};

  assign stat.pos        = byte_count[5:0];
  assign stat.last_round = (rnd == 6'd63);
  assign head_word       = chain[0];

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
      for (int i = 0; i < 16; i++) blk[i] <= '0;
      byte_count <= '0;
      rnd <= '0;
    end else begin
      if (cmd.take_byte || cmd.put_pad) begin
        case (wr_pos[1:0])
          2'd0: blk[wr_pos[5:2]][31:24] <= wr_byte;
          2'd1: blk[wr_pos[5:2]][23:16] <= wr_byte;
          2'd2: blk[wr_pos[5:2]][15:8]  <= wr_byte;
          default: blk[wr_pos[5:2]][7:0] <= wr_byte;
        endcase
      end
      if (cmd.take_byte) byte_count <= byte_count + 61'd1;
      if (cmd.put_len) begin
        blk[14] <= bits[63:32];
        blk[15] <= bits[31:0];
      end
      if (cmd.start) rnd <= '0;
      if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
        for (int i = 0; i < 16; i++) blk[i] <= '0;
      end
      if (cmd.emit_shift) begin
        for (int i = 0; i < 7; i++) chain[i] <= chain[i+1];
        chain[7] <= chain[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 16; i++) win[i] <= blk[i];
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_t;
      for (int i = 7; i > 0; i--) v[i] <= v[i-1];
      v[4] <= v[3] + t1;
      v[0] <= t1 + t2;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sha256_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha256_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire sha256_pkg::in_req_t   in_req,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_index,
  output sha256_pkg::sha_cmd_t       cmd,
  input  wire sha256_pkg::sha_stat_t stat
);
  import sha256_pkg::*;

  ctl_state_t state, state_next;
  logic       fin;        // padding still to finish
  logic       len_done;   // length has been placed in the block
  logic       fin_next, len_done_next;
  logic [2:0] out_index_next;
  logic       take, ends_blk, out_fire;
  logic       pad_seen, pad_seen_next;

  assign take     = in_valid && (state == ST_IDLE);
  assign ends_blk = in_req.has_byte && (stat.pos == 6'd63);
  assign out_fire = (state == ST_EMIT) && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin <= 1'b0;
      len_done <= 1'b0;
      out_index <= '0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      len_done <= len_done_next;
      out_index <= out_index_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_next = fin;
    len_done_next = len_done;
    out_index_next = out_index;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          fin_next = in_req.message_end;
          len_done_next = 1'b0;
          if (ends_blk) state_next = ST_LOAD;
          else if (in_req.message_end) state_next = ST_PAD;
        end
      end
      // Block bytes are settled here, so the load sees the final byte.
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (stat.last_round) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!fin) state_next = ST_IDLE;
        else if (len_done) begin
          state_next = ST_EMIT;
          out_index_next = '0;
        end else state_next = ST_PAD;
      end
      ST_PAD: begin
        // Pad byte placed here on the first pass; length goes in only when it fits.
        state_next = ST_LOAD;
        if (pad_seen || (stat.pos < 6'd56)) len_done_next = 1'b1;
      end
      ST_EMIT: begin
        if (out_fire) begin
          out_index_next = out_index + 3'd1;
          if (out_index == 3'd7) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Second pass through ST_PAD (extra length block) writes no pad byte.
  always_ff @(posedge clk) begin
    if (rst) pad_seen <= 1'b0;
    else pad_seen <= pad_seen_next;
  end
  always_comb begin
    pad_seen_next = pad_seen;
    if (state == ST_IDLE) pad_seen_next = 1'b0;
    else if (state == ST_PAD) pad_seen_next = 1'b1;
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take_byte = take && in_req.has_byte;
      end
      ST_LOAD: cmd.start = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD: cmd.fold = 1'b1;
      ST_PAD: begin
        cmd.put_pad = !pad_seen;
        cmd.put_len = pad_seen || (stat.pos < 6'd56);
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit_shift = out_fire;
        cmd.reinit = out_fire && (out_index == 3'd7);
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_EMIT)
    else $error("output outside emit");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_stall) |=> $stable(out_index))
    else $error("index moved under stall");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && stat.last_round) |=> state == ST_FOLD)
    else $error("round count overrun");
endmodule
`default_nettype wire
